### design/hsv2rgb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// shared constants, lookup tables and types for the hsv to rgb converter
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int unsigned HUE_CIRCLE   = 360;
  localparam int unsigned SECTOR_SPAN  = 60;
  localparam int unsigned PERCENT_FULL = 100;
  localparam int unsigned CHANNEL_FULL = 255;

  // reciprocal constants, exact for the operand ranges that reach them
  localparam int unsigned DIV100_K     = 5243;
  localparam int unsigned DIV100_SHIFT = 19;
  localparam int unsigned DIV60_K      = 17477;
  localparam int unsigned DIV60_SHIFT  = 20;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  // (hi * 256) mod 360 for the upper hue byte
  typedef logic [8:0] hue_tbl_t [256];
  // clamped brightness percent scaled to 0..255
  typedef logic [7:0] top_tbl_t [128];

  function automatic hue_tbl_t build_hue_hi_tbl();
    hue_tbl_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = 9'((i * 256) % HUE_CIRCLE);
    end
    return t;
  endfunction

  function automatic top_tbl_t build_top_tbl();
    top_tbl_t t;
    int unsigned p;
    for (int i = 0; i < 128; i++) begin
      p = (i > PERCENT_FULL) ? PERCENT_FULL : i;
      t[i] = 8'((p * CHANNEL_FULL) / PERCENT_FULL);
    end
    return t;
  endfunction

  localparam hue_tbl_t HUE_HI_MOD = build_hue_hi_tbl();
  localparam top_tbl_t TOP_TBL    = build_top_tbl();

endpackage

### design/hsv2rgb_div_const.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_div_const
// one-stage division by a constant: registered reciprocal multiply, shift out
// ----------------------------------------------------------------------------
module hsv2rgb_div_const #(
  parameter int unsigned XW = 15,
  parameter int unsigned QW = 8,
  parameter int unsigned K  = 5243,
  parameter int unsigned S  = 19
) (
  input  logic          clk,
  input  logic [XW-1:0] x,
  output logic [QW-1:0] q
);

  localparam int unsigned KW = $clog2(K + 1);
  localparam int unsigned PW = XW + KW;

  logic [PW-1:0] prod_r;
  logic [PW-1:0] prod_nxt;

  assign prod_nxt = PW'(x) * PW'(K);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign q = prod_r[S+QW-1:S];

endmodule

### design/hsv_to_rgb_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// integer hsv (degrees, percent, percent) to 8-bit rgb, six-stage pipeline
// ----------------------------------------------------------------------------
// usage:
//   a request is taken on every rising edge where start is high and busy is
//   low; busy is always low, so one request per clock is accepted
//   in_hue is any 16-bit value (reduced mod 360), saturation and brightness
//   above 100 are treated as 100
//   the rgb result appears on out_red/out_green/out_blue for one cycle,
//   flagged by out_valid, once the request has passed through every stage
//   throughput is one request per cycle; between the first and last stages,
//   the two reciprocal-multiply dividers (by 100 and by 60) and the two
//   products feeding them each own a pipeline stage
//   the receiver cannot stall, so nothing is held back and nothing queues
//   reset (rst_n low, synchronous) clears all valid bits; requests in flight
//   are dropped and out_valid stays low until new results arrive
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter
  import hsv2rgb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_hue,
  input  logic [6:0]  in_saturation,
  input  logic [6:0]  in_brightness,
  output logic        out_valid,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue
);

  localparam logic [6:0] PCT_MAX  = 7'(PERCENT_FULL);
  localparam logic [9:0] HUE_MOD  = 10'(HUE_CIRCLE);
  // first hue of each sector past the first
  localparam logic [8:0] SEC1_BASE = 9'(1 * SECTOR_SPAN);
  localparam logic [8:0] SEC2_BASE = 9'(2 * SECTOR_SPAN);
  localparam logic [8:0] SEC3_BASE = 9'(3 * SECTOR_SPAN);
  localparam logic [8:0] SEC4_BASE = 9'(4 * SECTOR_SPAN);
  localparam logic [8:0] SEC5_BASE = 9'(5 * SECTOR_SPAN);

  logic accept;

  // no backpressure anywhere in the pipe
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // --------------------------------------------------------------------------
  // stage 1: hue mod 360, brightness to top level, inverse saturation
  // --------------------------------------------------------------------------
  logic       v1_r;
  logic [8:0] hue1_r, hue1_nxt;
  logic [7:0] top1_r, top1_nxt;
  logic [6:0] isat1_r, isat1_nxt;
  logic [9:0] hue_sum;
  logic [6:0] sat_clamp;

  // upper byte folded through a table, lower byte added, one correction
  assign hue_sum   = {1'b0, HUE_HI_MOD[in_hue[15:8]]} + {2'b00, in_hue[7:0]};
  assign hue1_nxt  = (hue_sum >= HUE_MOD) ? 9'(hue_sum - HUE_MOD) : hue_sum[8:0];
  assign top1_nxt  = TOP_TBL[in_brightness];
  assign sat_clamp = (in_saturation > PCT_MAX) ? PCT_MAX : in_saturation;
  assign isat1_nxt = PCT_MAX - sat_clamp;

  always_ff @(posedge clk) begin
    hue1_r  <= hue1_nxt;
    top1_r  <= top1_nxt;
    isat1_r <= isat1_nxt;
  end

  // --------------------------------------------------------------------------
  // stage 2: sector and remainder, top * (100 - sat)
  // --------------------------------------------------------------------------
  logic       v2_r;
  sector_t    sector2_r, sector2_nxt;
  logic [5:0] rem2_r, rem2_nxt;
  logic [7:0] top2_r;
  logic [14:0] prod2_r, prod2_nxt;
  logic [8:0] base;

  // sector from five threshold compares, remainder by subtracting the base
  always_comb begin
    if (hue1_r >= SEC5_BASE) begin
      sector2_nxt = SEC_MAG_RED;
      base        = SEC5_BASE;
    end else if (hue1_r >= SEC4_BASE) begin
      sector2_nxt = SEC_BLU_MAG;
      base        = SEC4_BASE;
    end else if (hue1_r >= SEC3_BASE) begin
      sector2_nxt = SEC_CYN_BLU;
      base        = SEC3_BASE;
    end else if (hue1_r >= SEC2_BASE) begin
      sector2_nxt = SEC_GRN_CYN;
      base        = SEC2_BASE;
    end else if (hue1_r >= SEC1_BASE) begin
      sector2_nxt = SEC_YEL_GRN;
      base        = SEC1_BASE;
    end else begin
      sector2_nxt = SEC_RED_YEL;
      base        = '0;
    end
    rem2_nxt = 6'(hue1_r - base);
  end

  assign prod2_nxt = 15'(top1_r) * 15'(isat1_r);

  always_ff @(posedge clk) begin
    sector2_r <= sector2_nxt;
    rem2_r    <= rem2_nxt;
    top2_r    <= top1_r;
    prod2_r   <= prod2_nxt;
  end

  // --------------------------------------------------------------------------
  // stage 3: bottom = prod / 100 (reciprocal multiply registered in divider)
  // --------------------------------------------------------------------------
  logic       v3_r;
  sector_t    sector3_r;
  logic [5:0] rem3_r;
  logic [7:0] top3_r;
  logic [7:0] bottom_q;

  hsv2rgb_div_const #(
    .XW (15),
    .QW (8),
    .K  (DIV100_K),
    .S  (DIV100_SHIFT)
  ) u_div100 (
    .clk (clk),
    .x   (prod2_r),
    .q   (bottom_q)
  );

  always_ff @(posedge clk) begin
    sector3_r <= sector2_r;
    rem3_r    <= rem2_r;
    top3_r    <= top2_r;
  end

  // --------------------------------------------------------------------------
  // stage 4: (top - bottom) * rem
  // --------------------------------------------------------------------------
  logic        v4_r;
  sector_t     sector4_r;
  logic [7:0]  top4_r, bottom4_r;
  logic [7:0]  diff;
  logic [13:0] sprod4_r, sprod4_nxt;

  assign diff       = top3_r - bottom_q;
  assign sprod4_nxt = 14'(diff) * 14'(rem3_r);

  always_ff @(posedge clk) begin
    sector4_r <= sector3_r;
    top4_r    <= top3_r;
    bottom4_r <= bottom_q;
    sprod4_r  <= sprod4_nxt;
  end

  // --------------------------------------------------------------------------
  // stage 5: step = sprod / 60
  // --------------------------------------------------------------------------
  logic       v5_r;
  sector_t    sector5_r;
  logic [7:0] top5_r, bottom5_r;
  logic [7:0] step_q;

  hsv2rgb_div_const #(
    .XW (14),
    .QW (8),
    .K  (DIV60_K),
    .S  (DIV60_SHIFT)
  ) u_div60 (
    .clk (clk),
    .x   (sprod4_r),
    .q   (step_q)
  );

  always_ff @(posedge clk) begin
    sector5_r <= sector4_r;
    top5_r    <= top4_r;
    bottom5_r <= bottom4_r;
  end

  // --------------------------------------------------------------------------
  // stage 6: ramps and channel routing into the output registers
  // --------------------------------------------------------------------------
  logic [7:0] rise, fall;
  logic [7:0] red_nxt, green_nxt, blue_nxt;
  logic [7:0] out_red_r, out_green_r, out_blue_r;
  logic       out_valid_r;

  assign rise = bottom5_r + step_q;
  assign fall = top5_r - step_q;

  always_comb begin
    case (sector5_r)
      SEC_RED_YEL: begin
        red_nxt = top5_r;    green_nxt = rise;      blue_nxt = bottom5_r;
      end
      SEC_YEL_GRN: begin
        red_nxt = fall;      green_nxt = top5_r;    blue_nxt = bottom5_r;
      end
      SEC_GRN_CYN: begin
        red_nxt = bottom5_r; green_nxt = top5_r;    blue_nxt = rise;
      end
      SEC_CYN_BLU: begin
        red_nxt = bottom5_r; green_nxt = fall;      blue_nxt = top5_r;
      end
      SEC_BLU_MAG: begin
        red_nxt = rise;      green_nxt = bottom5_r; blue_nxt = top5_r;
      end
      default: begin
        red_nxt = top5_r;    green_nxt = bottom5_r; blue_nxt = fall;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    out_red_r   <= red_nxt;
    out_green_r <= green_nxt;
    out_blue_r  <= blue_nxt;
  end

  // valid bits travel alongside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= accept;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      out_valid_r <= v5_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
`ifndef ASSERT_OFF
  // remainder from the sector split stays inside one sector
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (rem2_r < 6'(SECTOR_SPAN)))
    else $error("sector remainder out of range");

  // minimum never exceeds maximum after the divide by 100
  a_bottom_le_top: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (bottom_q <= top3_r))
    else $error("bottom channel above top channel");

  // ramp step fits between min and max, so rise and fall do not wrap
  a_step_fits: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r |-> (step_q <= 8'(top5_r - bottom5_r)))
    else $error("ramp step exceeds channel span");

  // a reset cycle leaves no result strobe behind it
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe after reset");
`endif

endmodule
